>>> rtl/sqsyn_pkg.sv
// shared types, constants and tone tables of the square-wave synth
package sqsyn_pkg;

  // default sizes handed to the top level parameters
  localparam int MELODY_LENGTH_DEF     = 16;
  localparam int EVENT_QUEUE_DEPTH_DEF = 8;

  // field widths
  localparam int AMP_W       = 31;
  localparam int CHUNK_W     = 8;
  localparam int SAMPLE_W    = 32;
  localparam int CODE_W      = 3;
  localparam int KIND_W      = 2;
  localparam int LEN_W       = 13;
  localparam int NOTE_HALF_W = 4;
  localparam int FX_HALF_W   = 7;
  localparam int ROM_IDX_W   = 4;

  // register reset values
  localparam logic [AMP_W-1:0]   AMP_RESET   = 31'd536870911;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 8'd128;

  // register indexes
  typedef enum logic [0:0] {
    REG_AMPLITUDE    = 1'b0,
    REG_CHUNK_LENGTH = 1'b1
  } reg_index_t;

  // event codes
  localparam logic [CODE_W-1:0] EV_FLAP  = 3'd0;
  localparam logic [CODE_W-1:0] EV_SCORE = 3'd1;
  localparam logic [CODE_W-1:0] EV_DIE   = 3'd2;
  localparam logic [CODE_W-1:0] EV_TAP   = 3'd3;
  localparam logic [CODE_W-1:0] EV_START = 3'd4;
  localparam logic [CODE_W-1:0] EV_STOP  = 3'd5;

  localparam logic [KIND_W-1:0] DIE_KIND = 2'd2;

  // die sweep: floor((4800 + k) / 132) as (x * 15888) >> 21, exact for x < 32768
  localparam int               DIE_X_W   = 14;
  localparam int               DIE_SHIFT = 21;
  localparam logic [DIE_X_W-1:0] DIE_BASE  = 14'd4800;
  localparam logic [DIE_X_W-1:0] DIE_RECIP = 14'd15888;

  // classified input item
  typedef enum logic [1:0] {
    CLS_TICK  = 2'd0,
    CLS_EVENT = 2'd1,
    CLS_DROP  = 2'd2
  } item_class_t;

  typedef struct packed {
    item_class_t       cls;
    logic [CODE_W-1:0] code;
  } item_t;

  // one transfer into or out of the item queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } item_xfer_t;

  // configuration write bus
  typedef struct packed {
    logic             we;
    reg_index_t       addr;
    logic [AMP_W-1:0] data;
  } cfg_write_t;

  // melody half-periods in samples, zero is a rest
  function automatic logic [NOTE_HALF_W-1:0] rom_half(input logic [ROM_IDX_W-1:0] idx);
    logic [NOTE_HALF_W-1:0] h;
    case (idx)
      4'd0:    h = 4'd15;
      4'd1:    h = 4'd12;
      4'd2:    h = 4'd10;
      4'd3:    h = 4'd12;
      4'd4:    h = 4'd15;
      4'd5:    h = 4'd13;
      4'd6:    h = 4'd12;
      4'd7:    h = 4'd0;
      4'd8:    h = 4'd10;
      4'd9:    h = 4'd12;
      4'd10:   h = 4'd13;
      4'd11:   h = 4'd15;
      4'd12:   h = 4'd11;
      4'd13:   h = 4'd12;
      4'd14:   h = 4'd13;
      4'd15:   h = 4'd15;
      default: h = 4'd0;
    endcase
    return h;
  endfunction

  // melody note lengths in samples
  function automatic logic [LEN_W-1:0] rom_len(input logic [ROM_IDX_W-1:0] idx);
    logic [LEN_W-1:0] n;
    case (idx)
      4'd6:    n = 13'd3200;
      4'd7:    n = 13'd800;
      4'd15:   n = 13'd4800;
      default: n = 13'd1600;
    endcase
    return n;
  endfunction

  // effect lengths in samples
  function automatic logic [LEN_W-1:0] fx_len(input logic [KIND_W-1:0] kind);
    logic [LEN_W-1:0] n;
    case (kind)
      2'd0:    n = 13'd960;
      2'd1:    n = 13'd1280;
      2'd2:    n = 13'd4800;
      2'd3:    n = 13'd640;
      default: n = 13'd640;
    endcase
    return n;
  endfunction

  // effect starting half-periods
  function automatic logic [FX_HALF_W-1:0] fx_half(input logic [KIND_W-1:0] kind);
    logic [FX_HALF_W-1:0] h;
    case (kind)
      2'd0:    h = 7'd9;
      2'd1:    h = 7'd7;
      2'd2:    h = 7'd36;
      2'd3:    h = 7'd12;
      default: h = 7'd12;
    endcase
    return h;
  endfunction

endpackage

>>> rtl/sqsyn_front.sv
// front end: accepts input items, classifies them and drops unknown events
module sqsyn_front import sqsyn_pkg::*; (
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              func,
  input  logic [CODE_W-1:0] event_code,
  input  logic              queue_full,
  output item_xfer_t        push
);

  item_class_t cls;

  // tick, queued event, or event code that is never queued
  always_comb begin
    if (!func) begin
      cls = CLS_TICK;
    end else if (event_code <= EV_STOP) begin
      cls = CLS_EVENT;
    end else begin
      cls = CLS_DROP;
    end
  end

  assign item_stall      = queue_full;
  assign push.valid      = item_valid && !queue_full && (cls != CLS_DROP);
  assign push.item.cls   = cls;
  assign push.item.code  = event_code;

endmodule

>>> rtl/sqsyn_queue.sv
// two-entry item queue between the front and back ends
module sqsyn_queue import sqsyn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_xfer_t push,
  input  logic       pop,
  output item_xfer_t head,
  output logic       full
);

  item_t      slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.item;
    end
  end

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

endmodule

>>> rtl/sqsyn_back.sv
// back end: event queue, melody and effect voices, sample output register
module sqsyn_back import sqsyn_pkg::*; #(
  parameter int MELODY_LENGTH     = MELODY_LENGTH_DEF,
  parameter int EVENT_QUEUE_DEPTH = EVENT_QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_write_t                 cfg,
  input  item_xfer_t                 head,
  output logic                       pop,
  output logic                       sample_valid,
  input  logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int PW    = (MELODY_LENGTH > 1) ? $clog2(MELODY_LENGTH) : 1;
  localparam int CW    = $clog2(EVENT_QUEUE_DEPTH + 1);
  localparam int IW    = (EVENT_QUEUE_DEPTH > 1) ? $clog2(EVENT_QUEUE_DEPTH) : 1;
  localparam int HEAD1 = (EVENT_QUEUE_DEPTH > 1) ? 1 : 0;

  // voice state
  typedef struct packed {
    logic                   music_on;
    logic [PW-1:0]          pos;
    logic [LEN_W-1:0]       left;
    logic [NOTE_HALF_W-1:0] nhalf;
    logic [NOTE_HALF_W-1:0] ncnt;
    logic                   npol;
    logic [CHUNK_W-1:0]     cpos;
    logic                   e_act;
    logic [KIND_W-1:0]      kind;
    logic [LEN_W-1:0]       eidx;
    logic [FX_HALF_W-1:0]   ehalf;
    logic [FX_HALF_W-1:0]   ecnt;
    logic                   epol;
  } voice_t;

  logic [AMP_W-1:0]   amplitude;
  logic [CHUNK_W-1:0] chunk_length;
  voice_t             voice;
  voice_t             voice_next;
  logic [CODE_W-1:0]  ev_fifo [EVENT_QUEUE_DEPTH];
  logic [CW-1:0]      ev_count;
  logic [1:0]         npop;
  logic [SAMPLE_W-1:0] smp;
  logic               out_ready;
  logic               tick_go;
  logic               event_go;

  // load the note at the current melody position
  function automatic voice_t load_tone(input voice_t v_in);
    voice_t v;
    v       = v_in;
    v.left  = rom_len(ROM_IDX_W'(v.pos));
    v.nhalf = rom_half(ROM_IDX_W'(v.pos));
    v.ncnt  = '0;
    v.npol  = 1'b0;
    return v;
  endfunction

  // act on one event taken from the queue
  function automatic voice_t take_event(input voice_t v_in, input logic [CODE_W-1:0] ev);
    voice_t v;
    v = v_in;
    case (ev)
      EV_START: begin
        if (!v.music_on) begin
          v.pos      = '0;
          v          = load_tone(v);
          v.music_on = 1'b1;
          v.cpos     = '0;
        end
      end
      EV_STOP: begin
        v.music_on = 1'b0;
      end
      EV_FLAP, EV_SCORE, EV_DIE, EV_TAP: begin
        v.e_act = 1'b1;
        v.kind  = ev[KIND_W-1:0];
        v.eidx  = '0;
        v.ehalf = fx_half(ev[KIND_W-1:0]);
        v.ecnt  = '0;
        v.epol  = 1'b0;
      end
      default: ;
    endcase
    return v;
  endfunction

  assign out_ready = !sample_valid || !sample_stall;
  assign tick_go   = head.valid && (head.item.cls == CLS_TICK) && out_ready;
  assign event_go  = head.valid && (head.item.cls != CLS_TICK);
  assign pop       = tick_go || event_go;

  // one tick: optional event take, one voice step, chunk boundary take
  always_comb begin
    voice_t                 v;
    logic [DIE_X_W-1:0]     die_x;
    logic [2*DIE_X_W-1:0]   die_prod;
    logic [FX_HALF_W:0]     ec;
    logic [NOTE_HALF_W:0]   nc;
    logic [PW:0]            nx;
    logic [AMP_W:0]         amp_ext;
    logic                   neg;
    logic                   loud;
    v        = voice;
    npop     = 2'd0;
    neg      = 1'b0;
    loud     = 1'b0;
    nc       = '0;
    nx       = '0;
    amp_ext  = {1'b0, amplitude};
    if (!v.e_act && !v.music_on && (ev_count != '0)) begin
      v    = take_event(v, ev_fifo[0]);
      npop = 2'd1;
    end
    die_x    = DIE_BASE + DIE_X_W'(v.eidx);
    die_prod = die_x * DIE_RECIP;
    ec       = {1'b0, v.ecnt} + 1'b1;
    if (v.e_act) begin
      // effect voice
      if (v.ehalf != '0) begin
        loud = 1'b1;
        neg  = v.epol;
        if (ec >= {1'b0, v.ehalf}) begin
          v.epol = ~v.epol;
          v.ecnt = '0;
          if (v.kind == DIE_KIND) begin
            v.ehalf = die_prod[DIE_SHIFT +: FX_HALF_W];
          end
        end else begin
          v.ecnt = ec[FX_HALF_W-1:0];
        end
      end
      v.eidx = v.eidx + 1'b1;
      if (v.eidx >= fx_len(v.kind)) begin
        v.e_act = 1'b0;
      end
    end else if (v.music_on) begin
      // melody voice
      if (v.left == '0) begin
        nx = {1'b0, v.pos} + 1'b1;
        if (nx >= (PW+1)'(MELODY_LENGTH)) begin
          nx = '0;
        end
        v.pos = nx[PW-1:0];
        v     = load_tone(v);
      end
      if (v.nhalf != '0) begin
        loud = 1'b1;
        neg  = v.npol;
        nc   = {1'b0, v.ncnt} + 1'b1;
        if (nc >= {1'b0, v.nhalf}) begin
          v.npol = ~v.npol;
          v.ncnt = '0;
        end else begin
          v.ncnt = nc[NOTE_HALF_W-1:0];
        end
      end
      if (v.left != '0) begin
        v.left = v.left - 1'b1;
      end
      // chunk boundary
      v.cpos = v.cpos + 1'b1;
      if (v.cpos == chunk_length) begin
        v.cpos = '0;
        if (ev_count > CW'(npop)) begin
          v    = take_event(v, (npop == 2'd0) ? ev_fifo[0] : ev_fifo[HEAD1]);
          npop = npop + 2'd1;
        end
      end
    end
    if (!loud) begin
      smp = '0;
    end else if (neg) begin
      // two's complement negate, a zero amplitude stays zero
      smp = SAMPLE_W'(~amp_ext + 1'b1);
    end else begin
      smp = SAMPLE_W'(amp_ext);
    end
    voice_next = v;
  end

  // control state, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= AMP_RESET;
      chunk_length <= CHUNK_RESET;
      voice        <= '0;
      ev_count     <= '0;
      sample_valid <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.addr)
          REG_AMPLITUDE:    amplitude    <= cfg.data;
          REG_CHUNK_LENGTH: chunk_length <= cfg.data[CHUNK_W-1:0];
          default: ;
        endcase
      end
      if (tick_go) begin
        voice        <= voice_next;
        ev_count     <= ev_count - CW'(npop);
        sample_valid <= 1'b1;
      end else begin
        if (event_go && (head.item.cls == CLS_EVENT) &&
            (ev_count < CW'(EVENT_QUEUE_DEPTH))) begin
          ev_count <= ev_count + 1'b1;
        end
        if (!sample_stall) begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // event queue contents, shifted on take, written at the fill count
  always_ff @(posedge clk) begin
    if (tick_go) begin
      for (int i = 0; i < EVENT_QUEUE_DEPTH; i++) begin
        if (npop == 2'd1) begin
          ev_fifo[i] <= ev_fifo[(i + 1 < EVENT_QUEUE_DEPTH) ? i + 1 : i];
        end else if (npop == 2'd2) begin
          ev_fifo[i] <= ev_fifo[(i + 2 < EVENT_QUEUE_DEPTH) ? i + 2 : i];
        end
      end
    end else if (event_go && (head.item.cls == CLS_EVENT) &&
                 (ev_count < CW'(EVENT_QUEUE_DEPTH))) begin
      ev_fifo[ev_count[IW-1:0]] <= head.item.code;
    end
  end

  // sample output register
  always_ff @(posedge clk) begin
    if (tick_go) begin
      sample <= smp;
    end
  end

endmodule

>>> rtl/square_wave_melody_and_effect_synth_unit.sv
// top level of the square-wave melody and effect synth
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    func, event_code
//  sample    out        sample_valid / sample_stall sample
//  cfg       in         cfg_we                     cfg_addr, cfg_wdata
//
// one item per cycle while the sample output is not stalled; a tick's sample is
// registered after its transfer (item queue write, then the voice step).
// each tick updates the voices, the event queue and up to two event takes;
// the die sweep uses one 14x14 constant multiply.
// reset is synchronous and clears voices, event queue count and the item queue.
// a stalled sample output stops ticks in the back end; events and further
// items still transfer until the two-entry item queue fills.
module square_wave_melody_and_effect_synth_unit import sqsyn_pkg::*; #(
  parameter int MELODY_LENGTH     = MELODY_LENGTH_DEF,
  parameter int EVENT_QUEUE_DEPTH = EVENT_QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       func,
  input  logic [CODE_W-1:0]          event_code,
  output logic                       sample_valid,
  input  logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [AMP_W-1:0]           cfg_wdata
);

  item_xfer_t push;
  item_xfer_t head;
  logic       queue_full;
  logic       queue_pop;
  cfg_write_t cfg;

  assign cfg.we   = cfg_we;
  assign cfg.addr = reg_index_t'(cfg_addr);
  assign cfg.data = cfg_wdata;

  // classify and accept
  sqsyn_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .event_code (event_code),
    .queue_full (queue_full),
    .push       (push)
  );

  // decoupling queue
  sqsyn_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (queue_pop),
    .head (head),
    .full (queue_full)
  );

  // voices and output
  sqsyn_back #(
    .MELODY_LENGTH     (MELODY_LENGTH),
    .EVENT_QUEUE_DEPTH (EVENT_QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .pop          (queue_pop),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample)
  );

`ifndef SYNTHESIS
  // the back end only takes what the queue holds
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    queue_pop |-> head.valid)
    else $error("queue pop without a queued item");

  // a tick is never taken while the held sample is stalled
  a_tick_waits: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_stall && head.valid && (head.item.cls == CLS_TICK))
      |-> !queue_pop)
    else $error("tick taken while output sample is stalled");

  // dropped codes never reach the queue
  a_no_drop_push: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (push.item.cls != CLS_DROP))
    else $error("unknown event code pushed into the item queue");

  // no sample right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !sample_valid)
    else $error("sample valid right after reset");
`endif

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the square-wave melody and effect synth
module tb_top;
  import sqsyn_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int SEG_ITEMS     = 315;
  localparam int QUEUE_DEPTH   = EVENT_QUEUE_DEPTH_DEF;
  localparam int MELODY_NOTES  = MELODY_LENGTH_DEF;

  // item kinds and the two codes that the block never queues
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;
  localparam logic [CODE_W-1:0] EV_BAD_A = 3'd6;
  localparam logic [CODE_W-1:0] EV_BAD_B = 3'd7;

  // tone tables
  localparam int unsigned NOTE_HALF_TBL [16] = '{15, 12, 10, 12, 15, 13, 12, 0,
                                                 10, 12, 13, 15, 11, 12, 13, 15};
  localparam int unsigned NOTE_LEN_TBL [16] = '{1600, 1600, 1600, 1600, 1600, 1600, 3200, 800,
                                                1600, 1600, 1600, 1600, 1600, 1600, 1600, 4800};
  localparam int unsigned FX_LEN_TBL [4]  = '{960, 1280, 4800, 640};
  localparam int unsigned FX_HALF_TBL [4] = '{9, 7, 36, 12};
  localparam int unsigned SWEEP_BASE = 4800;
  localparam int unsigned SWEEP_DIV  = 132;

  localparam logic [SAMPLE_W-1:0] IDLE_LEVEL = '0;
  localparam logic [SAMPLE_W-1:0] RESET_PEAK = {1'b0, AMP_RESET};

  // directed stimulus, a fixed expectation only where it is obvious
  typedef struct packed {
    logic                fn;
    logic [CODE_W-1:0]   code;
    logic                fixed;
    logic [SAMPLE_W-1:0] want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{FUNC_TICK,  EV_FLAP,  1'b1, IDLE_LEVEL},  // idle after reset
    '{FUNC_EVENT, EV_BAD_A, 1'b0, IDLE_LEVEL},  // unknown codes are dropped
    '{FUNC_EVENT, EV_BAD_B, 1'b0, IDLE_LEVEL},
    '{FUNC_TICK,  EV_FLAP,  1'b1, IDLE_LEVEL},
    '{FUNC_EVENT, EV_STOP,  1'b0, IDLE_LEVEL},  // stop while music is off
    '{FUNC_TICK,  EV_BAD_B, 1'b1, IDLE_LEVEL},
    '{FUNC_EVENT, EV_TAP,   1'b0, IDLE_LEVEL},  // effect starts high
    '{FUNC_TICK,  EV_FLAP,  1'b1, RESET_PEAK},
    '{FUNC_TICK,  EV_FLAP,  1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_START, 1'b0, IDLE_LEVEL},  // fill the event queue
    '{FUNC_EVENT, EV_START, 1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_STOP,  1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_START, 1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_STOP,  1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_START, 1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_STOP,  1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_START, 1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_FLAP,  1'b0, IDLE_LEVEL},  // queue full, dropped
    '{FUNC_EVENT, EV_SCORE, 1'b0, IDLE_LEVEL},
    '{FUNC_EVENT, EV_DIE,   1'b0, IDLE_LEVEL},
    '{FUNC_TICK,  EV_TAP,   1'b0, IDLE_LEVEL},
    '{FUNC_TICK,  EV_DIE,   1'b0, IDLE_LEVEL}
  };

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       item_valid;
  logic                       item_stall;
  logic                       func;
  logic [CODE_W-1:0]          event_code;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       cfg_we;
  logic                       cfg_addr;
  logic [AMP_W-1:0]           cfg_wdata;

  square_wave_melody_and_effect_synth_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .event_code   (event_code),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // synth state as predicted
  logic [AMP_W-1:0]    amp_reg;
  logic [CHUNK_W-1:0]  chunk_reg;
  bit                  music_on;
  int unsigned         note_pos, note_left, note_half, note_cnt;
  bit                  note_neg;
  logic [CHUNK_W-1:0]  chunk_pos;
  bit                  fx_on;
  logic [KIND_W-1:0]   fx_kind;
  int unsigned         fx_idx, fx_half, fx_cnt;
  bit                  fx_neg;
  logic [CODE_W-1:0]   pending_events [$];
  logic [SAMPLE_W-1:0] want_samples [$];

  int mismatch_count = 0;
  int counted_items = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  logic [SAMPLE_W-1:0] got_want;

  function automatic void reset_synth();
    amp_reg   = AMP_RESET;
    chunk_reg = CHUNK_RESET;
    music_on  = 1'b0;
    note_pos  = 0;
    note_left = 0;
    note_half = 0;
    note_cnt  = 0;
    note_neg  = 1'b0;
    chunk_pos = '0;
    fx_on     = 1'b0;
    fx_kind   = '0;
    fx_idx    = 0;
    fx_half   = 0;
    fx_cnt    = 0;
    fx_neg    = 1'b0;
    pending_events.delete();
  endfunction

  function automatic logic [SAMPLE_W-1:0] level(input bit neg);
    logic [SAMPLE_W-1:0] a;
    a = {1'b0, amp_reg};
    return neg ? (32'd0 - a) : a;
  endfunction

  function automatic void fetch_note();
    note_left = NOTE_LEN_TBL[note_pos % 16];
    note_half = NOTE_HALF_TBL[note_pos % 16];
    note_cnt  = 0;
    note_neg  = 1'b0;
  endfunction

  function automatic void take_sound(input logic [CODE_W-1:0] ev);
    case (ev)
      EV_START: begin
        if (!music_on) begin
          note_pos = 0;
          fetch_note();
          music_on  = 1'b1;
          chunk_pos = '0;
        end
      end
      EV_STOP: music_on = 1'b0;
      EV_FLAP, EV_SCORE, EV_DIE, EV_TAP: begin
        fx_on   = 1'b1;
        fx_kind = ev[KIND_W-1:0];
        fx_idx  = 0;
        fx_half = FX_HALF_TBL[ev[KIND_W-1:0]];
        fx_cnt  = 0;
        fx_neg  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // one melody sample, advancing to the next note when the current one is used up
  function automatic logic [SAMPLE_W-1:0] melody_out();
    logic [SAMPLE_W-1:0] s;
    s = '0;
    if (note_left == 0) begin
      note_pos = (note_pos + 1 >= MELODY_NOTES) ? 0 : note_pos + 1;
      fetch_note();
    end
    if (note_half != 0) begin
      s = level(note_neg);
      note_cnt++;
      if (note_cnt >= note_half) begin
        note_neg = !note_neg;
        note_cnt = 0;
      end
    end
    if (note_left != 0) note_left--;
    return s;
  endfunction

  // one effect sample; the die effect re-times its half-period at each toggle
  function automatic logic [SAMPLE_W-1:0] effect_out();
    logic [SAMPLE_W-1:0] s;
    int unsigned k;
    s = '0;
    k = fx_idx;
    if (fx_half != 0) begin
      s = level(fx_neg);
      fx_cnt++;
      if (fx_cnt >= fx_half) begin
        fx_neg = !fx_neg;
        fx_cnt = 0;
        if (fx_kind == DIE_KIND) fx_half = ((SWEEP_BASE + k) / SWEEP_DIV) & 32'h7F;
      end
    end
    fx_idx = k + 1;
    if (fx_idx >= FX_LEN_TBL[fx_kind]) fx_on = 1'b0;
    return s;
  endfunction

  // sample for one tick, with event takes before it and at a chunk boundary
  function automatic logic [SAMPLE_W-1:0] render_tick();
    logic [SAMPLE_W-1:0] s;
    s = '0;
    if (!fx_on && !music_on && pending_events.size() != 0)
      take_sound(pending_events.pop_front());
    if (fx_on) begin
      s = effect_out();
    end else if (music_on) begin
      s = melody_out();
      chunk_pos = chunk_pos + 8'd1;
      if (chunk_pos == chunk_reg) begin
        chunk_pos = '0;
        if (pending_events.size() != 0) take_sound(pending_events.pop_front());
      end
    end
    return s;
  endfunction

  function automatic bit post_event(input logic [CODE_W-1:0] code);
    if (code <= EV_STOP && pending_events.size() < QUEUE_DEPTH) begin
      pending_events.push_back(code);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  // offer one item until its transfer, then predict what it causes
  task automatic offer_item(input logic fn, input logic [CODE_W-1:0] code,
                            input logic fixed, input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] s;
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    func       <= fn;
    event_code <= code;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (fn == FUNC_TICK) begin
      s = render_tick();
      want_samples.push_back(fixed ? want : s);
      counted_items++;
    end else if (post_event(code)) begin
      counted_items++;
    end
  endtask

  // wait for every expected sample, then let queued events settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (want_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [AMP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AMPLITUDE) amp_reg = val;
    else chunk_reg = val[CHUNK_W-1:0];
    @(posedge clk);
  endtask

  // mostly starts and stops, a few short effects, some unknown codes
  function automatic logic [CODE_W-1:0] pick_code();
    int w;
    w = $urandom_range(99);
    if (w < 38) return EV_START;
    if (w < 70) return EV_STOP;
    if (w < 76) return EV_TAP;
    if (w < 81) return EV_FLAP;
    if (w < 85) return EV_SCORE;
    return ($urandom_range(1) != 0) ? EV_BAD_A : EV_BAD_B;
  endfunction

  task automatic run_random(input int n);
    int start;
    int r;
    start = counted_items;
    while (counted_items - start < n) begin
      r = $urandom_range(99);
      if (r < 3) begin
        repeat ($urandom_range(10, 6)) offer_item(FUNC_EVENT, pick_code(), 1'b0, IDLE_LEVEL);
      end else if (r < 89) begin
        offer_item(FUNC_TICK, CODE_W'($urandom_range(7)), 1'b0, IDLE_LEVEL);
      end else begin
        offer_item(FUNC_EVENT, pick_code(), 1'b0, IDLE_LEVEL);
      end
    end
  endtask

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      sample_stall <= 1'b1;
    end else begin
      sample_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // compare each sample transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      if (want_samples.size() == 0) begin
        note_mismatch($sformatf("sample %0d with nothing expected", sample));
      end else begin
        got_want = want_samples.pop_front();
        if (sample !== got_want)
          note_mismatch($sformatf("sample %0d, expected %0d", sample, $signed(got_want)));
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("square_wave_melody_and_effect_synth_unit regression: fail");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    func         = FUNC_TICK;
    event_code   = EV_FLAP;
    sample_stall = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = REG_AMPLITUDE;
    cfg_wdata    = '0;
    reset_synth();
    send_gap_pct = 36;
    recv_gap_pct = 54;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      offer_item(DIRECTED_ROWS[i].fn, DIRECTED_ROWS[i].code,
                 DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

    // random segments, each with its own register settings
    for (int seg = 0; seg < 6; seg++) begin
      wait_idle();
      case (seg)
        0: begin
          write_reg(REG_AMPLITUDE, {AMP_W{1'b1}});
          write_reg(REG_CHUNK_LENGTH, AMP_W'(1));
        end
        1: begin
          write_reg(REG_AMPLITUDE, '0);
          write_reg(REG_CHUNK_LENGTH, AMP_W'(255));
        end
        2: begin
          send_gap_pct = 54;
          recv_gap_pct = 36;
          write_reg(REG_AMPLITUDE, AMP_W'($urandom));
          write_reg(REG_CHUNK_LENGTH, AMP_W'(0));
        end
        3: begin
          write_reg(REG_AMPLITUDE, AMP_W'(1));
          write_reg(REG_CHUNK_LENGTH, AMP_W'($urandom_range(16, 2)));
        end
        4: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
          write_reg(REG_AMPLITUDE, AMP_W'($urandom));
          write_reg(REG_CHUNK_LENGTH, AMP_W'($urandom_range(255, 1)));
        end
        default: begin
          write_reg(REG_AMPLITUDE, AMP_W'($urandom));
          write_reg(REG_CHUNK_LENGTH, AMP_W'(3));
          // the long die sweep runs through the last segment
          offer_item(FUNC_EVENT, EV_DIE, 1'b0, IDLE_LEVEL);
        end
      endcase
      run_random(SEG_ITEMS / 2);
      // back-pressure the output while items keep coming, or pause the input
      if (seg == 0) hold_request = 1'b1;
      if (seg == 3) wait_idle();
      run_random(SEG_ITEMS - SEG_ITEMS / 2);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("square_wave_melody_and_effect_synth_unit regression: pass");
    end else begin
      $display("square_wave_melody_and_effect_synth_unit regression: fail");
    end
    $finish;
  end

endmodule
